// ----- src/dosf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter package
// Shared constants, codes and types for the option strip filter.
// ----------------------------------------------------------------------------
package dosf_pkg;

	localparam int MAX_PACKET = 4096;
	localparam int POS_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MASK0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK3 = 3'd3;

	// Completion status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_IP   = 3'd1;
	localparam logic [2:0] ST_BAD_UDP  = 3'd2;
	localparam logic [2:0] ST_BAD_DHCP = 3'd3;
	localparam logic [2:0] ST_BAD_OPT  = 3'd4;
	localparam logic [2:0] ST_TOO_LONG = 3'd5;

	typedef enum logic [6:0] {
		PH_IP   = 7'b0000001,
		PH_UDP  = 7'b0000010,
		PH_DHCP = 7'b0000100,
		PH_CODE = 7'b0001000,
		PH_LEN  = 7'b0010000,
		PH_DATA = 7'b0100000,
		PH_STOP = 7'b1000000
	} phase_t;

	// One classified byte on its way from the parser to the output stage.
	typedef struct packed {
		logic [7:0] data;
		logic       keep;
		logic       last;
		logic [2:0] status;
	} rec_t;

	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] r;
		begin
			case (idx)
				2'd0: r = 8'h63;
				2'd1: r = 8'h82;
				2'd2: r = 8'h53;
				2'd3: r = 8'h63;
				default: r = 8'h00;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- src/dosf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter channels
// Input and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dosf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface dosf_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        done_res;
	logic [2:0]  status;
	logic [12:0] kept_length;

	modport source (output valid, output out_byte, output out_valid, output done_res,
		output status, output kept_length, input ready);
	modport sink (input valid, input out_byte, input out_valid, input done_res,
		input status, input kept_length, output ready);
endinterface

// ----- src/dhcp_option_strip_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter
// Checks an IPv4/UDP DHCP request byte by byte and drops masked options.
// ----------------------------------------------------------------------------
// Channel   Dir  Words                       Fields
// in_ch     in   one per packet byte          in_byte, in_last
// out_ch    out  one per input byte           out_byte, out_valid, done_res,
//                                             status, kept_length
// cfg       in   plain write, no read-back    cfg_we, cfg_index, cfg_wdata
//
// The block takes one word per cycle while the queue has space. The parser
// classifies each byte in the cycle it is accepted; the word is then written
// into a four-entry queue and from there into the output register. Reset
// clears the parser, the queue and the delete mask at once; there is no
// clearing pass. A stalled output fills the queue, and the input stops only
// when the queue is full.
// ----------------------------------------------------------------------------
module dhcp_option_strip_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	dosf_in_if.sink                         in_ch,
	dosf_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [dosf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dosf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import dosf_pkg::*;

	rec_t rec_in, rec_out;
	logic take, not_full, not_empty, pop;

	// A word enters whenever the queue has space.
	assign in_ch.ready = not_full;
	assign take        = in_ch.valid && not_full;

	dosf_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.b(in_ch.in_byte), .last(in_ch.in_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.rec(rec_in)
	);

	dosf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(take), .wdata(rec_in),
		.pop(pop), .rdata(rec_out), .not_full(not_full), .not_empty(not_empty)
	);

	dosf_back u_back (
		.clk(clk), .arst_n(arst_n), .q_avail(not_empty), .q_rec(rec_out),
		.q_pop(pop), .out_ch(out_ch)
	);

endmodule

// ----- src/dosf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter parser
// Walks the IP, UDP and DHCP headers and options, one byte a cycle when taken.
// ----------------------------------------------------------------------------
module dosf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [7:0]                     b,
	input  logic                           last,
	input  logic                           cfg_we,
	input  logic [dosf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dosf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output dosf_pkg::rec_t                 rec
);
	import dosf_pkg::*;

	logic [255:0]     mask_q;
	logic [POS_W-1:0] pos_q, n_pos;
	logic [5:0]       ihl_q, n_ihl;
	logic [15:0]      tot_q, n_tot, udp_q, n_udp;
	phase_t           phase_q, n_phase;
	logic [7:0]       obl_q, n_obl;
	logic             okept_q, n_okept;
	logic [2:0]       err_q, n_err, fc, st;
	logic             emit;
	logic [POS_W-1:0] q;
	logic [16:0]      lensum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MASK0: mask_q[63:0]    <= cfg_wdata;
				CFG_MASK1: mask_q[127:64]  <= cfg_wdata;
				CFG_MASK2: mask_q[191:128] <= cfg_wdata;
				CFG_MASK3: mask_q[255:192] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		n_pos = pos_q; n_ihl = ihl_q; n_tot = tot_q; n_udp = udp_q;
		n_phase = phase_q; n_obl = obl_q; n_okept = okept_q; n_err = err_q;
		fc = ST_OK; emit = 1'b0; q = '0;
		lensum = 17'(b) + 17'(pos_q) + 17'd1;
		if (32'(pos_q) >= MAX_PACKET) begin
			fc = ST_TOO_LONG;
		end else begin
			case (phase_q)
				PH_IP: begin
					if (pos_q == '0) begin
						n_ihl = {b[3:0], 2'b00};
						if (b[7:4] != 4'd4 || n_ihl < 6'd20) fc = ST_BAD_IP;
					end else if (pos_q == 13'd2) begin
						n_tot = {b, 8'h00};
					end else if (pos_q == 13'd3) begin
						n_tot = {tot_q[15:8], b};
					end else if (pos_q == 13'd9 && b != 8'd17) begin
						fc = ST_BAD_IP;
					end
					if (fc == ST_OK) begin
						emit = 1'b1;
						if (14'(pos_q) + 14'd1 == 14'(n_ihl)) begin
							if (16'(n_ihl) >= n_tot) fc = ST_BAD_IP;
							else if (17'(n_tot) <= 17'(n_ihl) + 17'd8) fc = ST_BAD_UDP;
							else n_phase = PH_UDP;
						end
					end
				end
				PH_UDP: begin
					q = pos_q - 13'(ihl_q);
					if (q == 13'd2 && b != 8'd0) fc = ST_BAD_UDP;
					else if (q == 13'd3 && b != 8'd67) fc = ST_BAD_UDP;
					else if (q == 13'd4) n_udp = {b, 8'h00};
					else if (q == 13'd5) n_udp = {udp_q[15:8], b};
					if (fc == ST_OK) begin
						emit = 1'b1;
						if (q == 13'd7) begin
							if (n_udp != tot_q - 16'(ihl_q)) fc = ST_BAD_UDP;
							else if (n_udp <= 16'd248) fc = ST_BAD_DHCP;
							else n_phase = PH_DHCP;
						end
					end
				end
				PH_DHCP: begin
					q = pos_q - 13'(ihl_q) - 13'd8;
					if (q == 13'd0 && b != 8'd1) fc = ST_BAD_DHCP;
					else if (q >= 13'd236 && q < 13'd240 && b != cookie_byte(q[1:0]))
						fc = ST_BAD_DHCP;
					if (fc == ST_OK) begin
						emit = 1'b1;
						if (q >= 13'd239) n_phase = PH_CODE;
					end
				end
				PH_CODE: begin
					if (16'(pos_q) >= tot_q) fc = ST_BAD_OPT;
					else if (b == 8'd0) emit = 1'b1;
					else if (b == 8'd255) n_phase = PH_STOP;
					else if (17'(pos_q) + 17'd1 == 17'(tot_q)) fc = ST_BAD_OPT;
					else begin
						n_okept = !mask_q[b];
						emit = n_okept;
						n_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (lensum >= 17'(tot_q)) fc = ST_BAD_OPT;
					else begin
						emit = okept_q;
						n_obl = b;
						n_phase = (b != 8'd0) ? PH_DATA : PH_CODE;
					end
				end
				PH_DATA: begin
					emit = okept_q;
					n_obl = obl_q - 8'd1;
					if (n_obl == 8'd0) n_phase = PH_CODE;
				end
				default: ;
			endcase
		end
		if (fc != ST_OK) begin
			n_phase = PH_STOP;
			if (err_q == ST_OK) n_err = fc;
		end
		if (32'(pos_q) <= MAX_PACKET) n_pos = pos_q + 13'd1;

		if (32'(n_pos) > MAX_PACKET) st = ST_TOO_LONG;
		else if (n_pos <= 13'd20) st = ST_BAD_IP;
		else if (n_err == ST_BAD_IP || (n_err == ST_OK && n_phase == PH_IP)) st = ST_BAD_IP;
		else if (n_tot > 16'(n_pos)) st = ST_BAD_IP;
		else if (n_err != ST_OK) st = n_err;
		else if (n_phase != PH_STOP) st = ST_BAD_OPT;
		else st = ST_OK;

		rec.data   = emit ? b : 8'h00;
		rec.keep   = emit;
		rec.last   = last;
		rec.status = last ? st : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ihl_q <= '0; tot_q <= '0; udp_q <= '0;
			phase_q <= PH_IP; obl_q <= '0; okept_q <= 1'b0; err_q <= ST_OK;
		end else if (take) begin
			if (last) begin
				pos_q <= '0; ihl_q <= '0; tot_q <= '0; udp_q <= '0;
				phase_q <= PH_IP; obl_q <= '0; okept_q <= 1'b0; err_q <= ST_OK;
			end else begin
				pos_q <= n_pos; ihl_q <= n_ihl; tot_q <= n_tot; udp_q <= n_udp;
				phase_q <= n_phase; obl_q <= n_obl; okept_q <= n_okept; err_q <= n_err;
			end
		end
	end

endmodule

// ----- src/dosf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module dosf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dosf_pkg::rec_t wdata,
	input  logic           pop,
	output dosf_pkg::rec_t rdata,
	output logic           not_full,
	output logic           not_empty
);
	import dosf_pkg::*;

	rec_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- src/dosf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter output stage
// Counts kept bytes and holds each result word until it is taken.
// ----------------------------------------------------------------------------
module dosf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_avail,
	input  dosf_pkg::rec_t q_rec,
	output logic           q_pop,
	dosf_out_if.source     out_ch
);
	import dosf_pkg::*;

	logic        valid_q;
	logic [12:0] kept_q, kept_n;
	rec_t        rec_q;
	logic [12:0] len_q;

	assign q_pop  = q_avail && (!valid_q || out_ch.ready);
	assign kept_n = kept_q + 13'(q_rec.keep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kept_q  <= '0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				kept_q  <= q_rec.last ? 13'd0 : kept_n;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
			len_q <= q_rec.last ? kept_n : 13'd0;
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.out_byte    = rec_q.data;
	assign out_ch.out_valid   = rec_q.keep;
	assign out_ch.done_res    = rec_q.last;
	assign out_ch.status      = rec_q.status;
	assign out_ch.kept_length = len_q;

endmodule

// ----- src/dosf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dosf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        o_valid,
	input logic        o_ready,
	input logic [7:0]  o_byte,
	input logic        o_kept,
	input logic        o_done,
	input logic [2:0]  o_status,
	input logic [12:0] o_len
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid)
		else $error("result word dropped while stalled");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_done |-> o_status == 3'd0 && o_len == 13'd0)
		else $error("status or length outside a done word");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_kept |-> o_byte == 8'd0)
		else $error("dropped byte not zero");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_done |-> o_len <= 13'd4096 && o_status <= 3'd5)
		else $error("kept length or status out of range");
endmodule

bind dhcp_option_strip_filter dosf_checker u_dosf_checker (
	.clk(clk), .arst_n(arst_n),
	.o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_byte(out_ch.out_byte),
	.o_kept(out_ch.out_valid), .o_done(out_ch.done_res),
	.o_status(out_ch.status), .o_len(out_ch.kept_length)
);

// ----- tb/tb_dhcp_option_strip_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option strip filter testbench
// Feeds well-formed and damaged DHCP requests byte by byte, predicts every
// output word with an internal parser model and compares field by field.
// ----------------------------------------------------------------------------
module tb_dhcp_option_strip_filter;
	import dosf_pkg::*;

	// Parser phases of the predictor.
	typedef enum int {
		P_IP, P_UDP, P_DHCP, P_CODE, P_LEN, P_DATA, P_STOP
	} pphase_t;

	// One expected output word.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic        done_res;
		logic [2:0]  status;
		logic [12:0] kept_length;
	} word_t;

	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_END = 8'd255;
	localparam logic [7:0] UDP_PROTO = 8'd17;
	localparam logic [7:0] BOOTREQUEST = 8'd1;
	localparam logic [7:0] SERVER_PORT = 8'd67;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dosf_in_if in_ch ();
	dosf_out_if out_ch ();

	dhcp_option_strip_filter dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Predictor state: a copy of the delete mask and of the packet parser.
	logic [63:0] strip_mask [4];
	int unsigned pos, ihl, tot_len, udp_len, opt_left, kept;
	pphase_t phase;
	bit opt_keep;
	int unsigned err;
	word_t expected_words [$];
	int errors;
	// Idle rates in percent; zero opens a stretch with no idling.
	int send_idle, recv_idle;

	function automatic void clear_packet();
		pos = 0; ihl = 0; tot_len = 0; udp_len = 0; opt_left = 0; kept = 0;
		phase = P_IP; opt_keep = 0; err = 0;
	endfunction

	function automatic void mark_fault(int unsigned code);
		if (err == 0)
			err = code;
		phase = P_STOP;
	endfunction

	function automatic logic [7:0] cookie(int unsigned i);
		case (i)
			0: return 8'h63;
			1: return 8'h82;
			2: return 8'h53;
			default: return 8'h63;
		endcase
	endfunction

	// Works out the output word for one accepted byte and queues it.
	function automatic void predict_byte(logic [7:0] b, logic last);
		word_t w;
		int unsigned p, q, n, st;
		bit keep;
		p = pos;
		keep = 0;
		w = '0;
		if (p >= MAX_PACKET) begin
			mark_fault(ST_TOO_LONG);
		end else begin
			case (phase)
				P_IP: begin
					if (p == 0) begin
						ihl = b[3:0] * 4;
						if (b[7:4] != 4 || ihl < 20)
							mark_fault(ST_BAD_IP);
					end else if (p == 2) begin
						tot_len = b << 8;
					end else if (p == 3) begin
						tot_len = tot_len | b;
					end else if (p == 9 && b != UDP_PROTO) begin
						mark_fault(ST_BAD_IP);
					end
					if (phase == P_IP) begin
						keep = 1;
						if (p + 1 == ihl) begin
							if (ihl >= tot_len)
								mark_fault(ST_BAD_IP);
							else if (tot_len <= ihl + 8)
								mark_fault(ST_BAD_UDP);
							else
								phase = P_UDP;
						end
					end
				end
				P_UDP: begin
					q = p - ihl;
					if (q == 2 && b != 0)
						mark_fault(ST_BAD_UDP);
					else if (q == 3 && b != SERVER_PORT)
						mark_fault(ST_BAD_UDP);
					else if (q == 4)
						udp_len = b << 8;
					else if (q == 5)
						udp_len = udp_len | b;
					if (phase == P_UDP) begin
						keep = 1;
						if (q == 7) begin
							if (udp_len != tot_len - ihl)
								mark_fault(ST_BAD_UDP);
							else if (udp_len - 8 <= 240)
								mark_fault(ST_BAD_DHCP);
							else
								phase = P_DHCP;
						end
					end
				end
				P_DHCP: begin
					q = p - ihl - 8;
					if (q == 0 && b != BOOTREQUEST)
						mark_fault(ST_BAD_DHCP);
					else if (q >= 236 && q < 240 && b != cookie(q - 236))
						mark_fault(ST_BAD_DHCP);
					if (phase == P_DHCP) begin
						keep = 1;
						if (q >= 239)
							phase = P_CODE;
					end
				end
				P_CODE: begin
					if (p >= tot_len) begin
						mark_fault(ST_BAD_OPT);
					end else if (b == OPT_PAD) begin
						keep = 1;
					end else if (b == OPT_END) begin
						phase = P_STOP;
					end else if (p + 1 == tot_len) begin
						mark_fault(ST_BAD_OPT);
					end else begin
						opt_keep = !strip_mask[b[7:6]][b[5:0]];
						keep = opt_keep;
						phase = P_LEN;
					end
				end
				P_LEN: begin
					if (b + p + 1 >= tot_len) begin
						mark_fault(ST_BAD_OPT);
					end else begin
						keep = opt_keep;
						opt_left = b;
						phase = (b != 0) ? P_DATA : P_CODE;
					end
				end
				P_DATA: begin
					keep = opt_keep;
					opt_left = (opt_left - 1) & 8'hff;
					if (opt_left == 0)
						phase = P_CODE;
				end
				default: ;
			endcase
		end
		if (p <= MAX_PACKET)
			pos = p + 1;
		if (keep) begin
			w.out_byte = b;
			w.out_valid = 1'b1;
			kept++;
		end
		if (last) begin
			n = pos;
			if (n > MAX_PACKET)
				st = ST_TOO_LONG;
			else if (n <= 20)
				st = ST_BAD_IP;
			else if (err == ST_BAD_IP || (err == 0 && phase == P_IP))
				st = ST_BAD_IP;
			else if (tot_len > n)
				st = ST_BAD_IP;
			else if (err != 0)
				st = err;
			else if (phase != P_STOP)
				st = ST_BAD_OPT;
			else
				st = ST_OK;
			w.done_res = 1'b1;
			w.status = st[2:0];
			w.kept_length = kept[12:0];
			clear_packet();
		end
		expected_words.push_back(w);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Sends one byte, waiting out the random idle gap and the handshake.
	// Valid stays high after the accepting edge until the next idle gap or
	// drain, so back-to-back bytes never see two assignments in one step.
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_byte(b, last);
	endtask

	task automatic send_packet(ref logic [7:0] pkt [$]);
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// Waits until every expected word has arrived, then lets the pipe settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		strip_mask[idx] = v;
	endtask

	task automatic set_masks(logic [63:0] m0, m1, m2, m3);
		drain();
		write_mask(CFG_MASK0, m0);
		write_mask(CFG_MASK1, m1);
		write_mask(CFG_MASK2, m2);
		write_mask(CFG_MASK3, m3);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Builds a request with nopt random options, an END if add_end is set and
	// trailer bytes past the total length; the caller may damage it afterwards.
	function automatic void build_request(ref logic [7:0] pkt [$], input int nopt,
		input bit add_end, input int trailer);
		int unsigned hl, total, code, len;
		pkt.delete();
		hl = 20 + 4 * $urandom_range(0, 2);
		pkt.push_back(8'h40 | (hl / 4));
		pkt.push_back($urandom_range(255));
		pkt.push_back(0); pkt.push_back(0);
		for (int i = 4; i < hl; i++)
			pkt.push_back(i == 9 ? UDP_PROTO : $urandom_range(255));
		pkt.push_back($urandom_range(255)); pkt.push_back($urandom_range(255));
		pkt.push_back(0); pkt.push_back(SERVER_PORT);
		pkt.push_back(0); pkt.push_back(0);
		pkt.push_back($urandom_range(255)); pkt.push_back($urandom_range(255));
		for (int i = 0; i < 240; i++)
			pkt.push_back(i == 0 ? BOOTREQUEST : (i >= 236 ? cookie(i - 236)
				: $urandom_range(255)));
		for (int k = 0; k < nopt; k++) begin
			if ($urandom_range(7) == 0) begin
				pkt.push_back(OPT_PAD);
			end else begin
				code = $urandom_range(1, 254);
				len = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 12);
				pkt.push_back(code);
				pkt.push_back(len);
				for (int j = 0; j < len; j++)
					pkt.push_back($urandom_range(255));
			end
		end
		if (add_end)
			pkt.push_back(OPT_END);
		pkt.push_back(OPT_PAD);
		total = pkt.size();
		for (int j = 0; j < trailer; j++)
			pkt.push_back($urandom_range(255));
		pkt[2] = total >> 8; pkt[3] = total & 8'hff;
		pkt[hl + 4] = (total - hl) >> 8; pkt[hl + 5] = (total - hl) & 8'hff;
	endfunction

	// Checks every accepted output word against the oldest expectation.
	always @(posedge clk) begin
		word_t w;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				w = expected_words.pop_front();
				if (out_ch.out_valid !== w.out_valid)
					report_mismatch("out_valid", out_ch.out_valid, w.out_valid);
				if (out_ch.out_byte !== w.out_byte)
					report_mismatch("out_byte", out_ch.out_byte, w.out_byte);
				if (out_ch.done_res !== w.done_res)
					report_mismatch("done_res", out_ch.done_res, w.done_res);
				if (out_ch.status !== w.status)
					report_mismatch("status", out_ch.status, w.status);
				if (out_ch.kept_length !== w.kept_length)
					report_mismatch("kept_length", out_ch.kept_length, w.kept_length);
			end
		end
		out_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// Short and damaged headers: IP, UDP and DHCP faults and the shortest packets.
	task automatic test_header_faults();
		logic [7:0] pkt [$];
		pkt = {8'h45}; send_packet(pkt);
		pkt = {8'hff, 8'h00}; send_packet(pkt);
		for (int f = 0; f < 9; f++) begin
			build_request(pkt, 3, 1, 0);
			case (f)
				0: pkt[0] = 8'h55;
				1: pkt[0] = 8'h44;
				2: pkt[9] = 8'd6;
				3: begin pkt[2] = 8'h00; pkt[3] = 8'd20; end
				4: begin pkt[2] = 8'h00; pkt[3] = 8'd24; end
				5: pkt[(pkt[0] & 15) * 4 + 2] = 8'h01;
				6: pkt[(pkt[0] & 15) * 4 + 5] ^= 8'h01;
				7: pkt[(pkt[0] & 15) * 4 + 8] = 8'd2;
				default: pkt[(pkt[0] & 15) * 4 + 8 + 237] = 8'h00;
			endcase
			send_packet(pkt);
		end
		build_request(pkt, 2, 1, 0);
		pkt = pkt[0:30];
		send_packet(pkt);
	endtask

	// Option walk cases: missing END, option cut by the total length, code
	// in the last byte, trailing bytes, and deletion of every option.
	task automatic test_option_cases();
		logic [7:0] pkt [$];
		build_request(pkt, 4, 0, 0); send_packet(pkt);
		build_request(pkt, 4, 1, 5); send_packet(pkt);
		build_request(pkt, 0, 1, 0);
		pkt[pkt.size() - 2] = 8'd12; pkt[pkt.size() - 1] = 8'd9;
		send_packet(pkt);
		build_request(pkt, 0, 1, 0);
		pkt[pkt.size() - 1] = 8'd12; pkt.push_back(8'h00);
		send_packet(pkt);
		set_masks('1, '1, '1, '1);
		build_request(pkt, 8, 1, 2); send_packet(pkt);
		set_masks('0, '0, '0, '0);
		build_request(pkt, 8, 1, 0); send_packet(pkt);
	endtask

	// Oversized packet runs past the maximum length.
	task automatic test_too_long();
		logic [7:0] pkt [$];
		build_request(pkt, 0, 0, 0);
		while (pkt.size() < MAX_PACKET + 3)
			pkt.push_back($urandom_range(255));
		send_packet(pkt);
	endtask

	// Random traffic, mostly well-formed requests with light damage. The
	// third packet runs with no idling on either side.
	task automatic test_random_traffic();
		logic [7:0] pkt [$];
		int sent;
		int npkt;
		sent = 0;
		npkt = 0;
		while (sent < 1300) begin
			if (npkt == 2) begin
				send_idle = 0; recv_idle = 0;
			end else begin
				send_idle = 26; recv_idle = 26;
			end
			build_request(pkt, $urandom_range(0, 6), $urandom_range(9) != 0,
				$urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
			if ($urandom_range(5) == 0)
				pkt[$urandom_range(pkt.size() - 1)] = $urandom_range(255);
			if ($urandom_range(11) == 0)
				pkt = pkt[0:$urandom_range(pkt.size() - 1)];
			send_packet(pkt);
			sent += pkt.size();
			npkt++;
			if ($urandom_range(2) == 0)
				set_masks(rand64() & rand64(), rand64() & rand64(),
					rand64() & rand64(), rand64() & rand64());
		end
		send_idle = 26; recv_idle = 26;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MASK0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		out_ch.ready = 1'b0;
		errors = 0;
		send_idle = 26;
		recv_idle = 26;
		for (int i = 0; i < 4; i++)
			strip_mask[i] = '0;
		clear_packet();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_faults();
		test_option_cases();
		test_too_long();
		set_masks(64'h5555_aaaa_0f0f_f0f0, '1, '0, 64'h8000_0000_0000_0001);
		test_random_traffic();
		drain();
		if (errors == 0)
			$display("dhcp_option_strip_filter verification clean");
		else
			$display("dhcp_option_strip_filter verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("dhcp_option_strip_filter verification failed");
		$finish;
	end

endmodule

// ----- dhcp_option_strip_filter.f -----
src/dosf_pkg.sv
src/dosf_if.sv
src/dosf_front.sv
src/dosf_queue.sv
src/dosf_back.sv
src/dhcp_option_strip_filter.sv
src/dosf_checker.sv
tb/tb_dhcp_option_strip_filter.sv
